FILE: rtl/upd_pkg.sv
// shared types and character constants for the url percent decoder
// no dependencies; imported by every module of the block
`default_nettype none

package upd_pkg;

    // most results one input item can cause
    localparam int RES_MAX = 4;
    localparam int RES_CNT_W = 3;

    // characters the decoder looks for
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // escape progress of the first stage
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_DIGIT   = 2'd2;

    // the result items of one input item, in output order
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [RES_MAX-1:0]      ends;
        logic [RES_CNT_W-1:0]    cnt;
    } t_res_set;

endpackage

`default_nettype wire

FILE: rtl/upd_in_stage.sv
// input register of the url percent decoder: holds one accepted item
// depends on upd_pkg
`default_nettype none

module upd_in_stage
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: rtl/upd_decode.sv
// decode step of the url percent decoder: escape and backslash state plus the
// logic that turns one input item into its result items; depends on upd_pkg
`default_nettype none

module upd_decode
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_res_set        o_res
);

    typedef struct packed {
        t_res_set res;
        logic     hb;
        logic     stop;
    } t_acc;

    logic [1:0] r_phase;
    logic [3:0] r_fd;
    logic       r_hb;
    logic       r_ended;
    logic [1:0] n_phase;
    logic [3:0] n_fd;
    logic       n_hb;
    logic       n_ended;
    t_acc       acc;
    logic [4:0] hv;

    // hex digit value, top bit set when the character is a hex digit
    function automatic logic [4:0] f_hex(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // append one result while there is room
    function automatic t_acc f_push(t_acc a, logic [7:0] b, logic e);
        t_acc r;
        r = a;
        for (int i = 0; i < RES_MAX; i++) begin
            if (a.res.cnt == RES_CNT_W'(i)) begin
                r.res.bytes[i] = b;
                r.res.ends[i]  = e;
            end
        end
        if (a.res.cnt < RES_CNT_W'(RES_MAX)) begin
            r.res.cnt = a.res.cnt + RES_CNT_W'(1);
        end
        return r;
    endfunction

    // second stage: one decoded byte through the backslash-n rewrite
    function automatic t_acc f_stage2(t_acc a, logic [7:0] b);
        t_acc r;
        r = a;
        if (!a.stop) begin
            if (b == CH_NUL) begin
                if (a.hb) begin
                    r = f_push(r, CH_BACKSLASH, 1'b0);
                end
                r.hb   = 1'b0;
                r      = f_push(r, CH_NUL, 1'b1);
                r.stop = 1'b1;
            end else if (a.hb) begin
                if (b == CH_LOWER_N) begin
                    r    = f_push(r, CH_NEWLINE, 1'b0);
                    r.hb = 1'b0;
                end else begin
                    r = f_push(r, CH_BACKSLASH, 1'b0);
                    if (b != CH_BACKSLASH) begin
                        r    = f_push(r, b, 1'b0);
                        r.hb = 1'b0;
                    end
                end
            end else if (b == CH_BACKSLASH) begin
                r.hb = 1'b1;
            end else begin
                r = f_push(r, b, 1'b0);
            end
        end
        return r;
    endfunction

    // one item: first stage, text end handling, next state
    always_comb begin
        acc      = '0;
        acc.hb   = r_hb;
        n_phase  = r_phase;
        n_fd     = r_fd;
        n_hb     = r_hb;
        n_ended  = r_ended;
        hv       = f_hex(i_byte);
        if (r_ended) begin
            // discard until the end of the text
            if (i_last) begin
                n_phase = PH_IDLE;
                n_fd    = 4'd0;
                n_hb    = 1'b0;
                n_ended = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_PERCENT: begin
                    if (hv[4]) begin
                        n_fd    = hv[3:0];
                        n_phase = PH_DIGIT;
                    end else begin
                        n_phase = PH_IDLE;
                        acc     = f_stage2(acc, CH_PERCENT);
                        if (!acc.stop) begin
                            if (i_byte == CH_PERCENT) begin
                                n_phase = PH_PERCENT;
                            end else begin
                                acc = f_stage2(acc, i_byte);
                            end
                        end
                    end
                end
                PH_DIGIT: begin
                    n_phase = PH_IDLE;
                    // a non-hex second character other than a zero byte is swallowed
                    acc = f_stage2(acc, hv[4] ? {r_fd, hv[3:0]} : {4'd0, r_fd});
                    if (i_byte == CH_NUL) begin
                        acc = f_stage2(acc, CH_NUL);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == CH_PERCENT) begin
                        n_phase = PH_PERCENT;
                    end else begin
                        acc = f_stage2(acc, i_byte);
                    end
                end
            endcase

            if (acc.stop) begin
                // decoded terminator: skip the rest of the text
                n_phase = PH_IDLE;
                n_fd    = 4'd0;
                n_hb    = 1'b0;
                n_ended = !i_last;
            end else if (i_last) begin
                // flush a pending escape and a held backslash
                if (n_phase == PH_PERCENT) begin
                    acc = f_stage2(acc, CH_PERCENT);
                end else if (n_phase == PH_DIGIT) begin
                    acc = f_stage2(acc, {4'd0, n_fd});
                end
                if (!acc.stop && acc.hb) begin
                    acc    = f_push(acc, CH_BACKSLASH, 1'b0);
                    acc.hb = 1'b0;
                end
                for (int i = 0; i < RES_MAX; i++) begin
                    if (acc.res.cnt == RES_CNT_W'(i + 1)) begin
                        acc.res.ends[i] = 1'b1;
                    end
                end
                n_phase = PH_IDLE;
                n_fd    = 4'd0;
                n_hb    = 1'b0;
                n_ended = 1'b0;
            end else begin
                n_hb = acc.hb;
            end
        end
    end

    // state advances when the item moves into the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fd    <= 4'd0;
            r_hb    <= 1'b0;
            r_ended <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_fd    <= n_fd;
            r_hb    <= n_hb;
            r_ended <= n_ended;
        end
    end

    assign o_res = acc.res;

endmodule

`default_nettype wire

FILE: rtl/upd_res_buf.sv
// result buffer of the url percent decoder: holds the results of one item and
// hands them out one per cycle while the receiver is ready; depends on upd_pkg
`default_nettype none

module upd_res_buf
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_res_set   i_res,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_byte,
    output logic            o_end,
    output logic            o_run_last
);

    logic [RES_MAX-1:0][7:0] r_bytes;
    logic [RES_MAX-1:0]      r_ends;
    logic [RES_CNT_W-1:0]    r_cnt;
    logic [RES_MAX-1:0][7:0] n_bytes;
    logic [RES_MAX-1:0]      n_ends;
    logic [RES_CNT_W-1:0]    n_cnt;
    logic                    emit;

    assign emit    = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    // free when empty or when the final result leaves this cycle
    assign o_free  = (r_cnt == '0) || (r_cnt == RES_CNT_W'(1) && i_ready);

    // shift out on each taken result, reload from the decode step
    always_comb begin
        n_bytes = r_bytes;
        n_ends  = r_ends;
        n_cnt   = r_cnt;
        if (emit) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                n_bytes[i] = r_bytes[i + 1];
                n_ends[i]  = r_ends[i + 1];
            end
            n_cnt = r_cnt - RES_CNT_W'(1);
        end
        if (i_load) begin
            n_bytes = i_res.bytes;
            n_ends  = i_res.ends;
            n_cnt   = i_res.cnt;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_ends  <= n_ends;
    end

    assign o_byte     = r_bytes[0];
    assign o_end      = r_ends[0];
    assign o_run_last = (r_cnt == RES_CNT_W'(1));

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder_core.sv
// url percent decoder: decodes %hh escapes, then rewrites backslash-n to newline
// and stops the text at a decoded zero byte.
// depends on upd_pkg, upd_in_stage, upd_decode, upd_res_buf
//
// input stream: one encoded character per item in s_axis_tdata, s_axis_tlast on
// the final character of a text. output stream: one decoded character per item,
// m_axis_tlast on the final decoded character of the text, m_axis_tuser set on
// the last result caused by one input item.
// an item passes through the input register and then the result buffer, which
// offers its first result. one input item is taken per cycle while each causes
// at most one result and the receiver is ready; an item that causes several
// results holds the input until they have left, since the result buffer hands
// out one result per cycle while the receiver is ready and takes the next item's
// results only as its last one leaves. items that cause no result also pass through it.
// receiver stalls hold the buffered result steady and back up into the input
// register and then s_axis_tready. reset (synchronous, active low) empties both
// stages and returns the decoder to the start of a text.
`default_nettype none

module url_percent_decoder_core
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // text_end
    output logic [0:0]      m_axis_tuser    // [0] run_last
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       buf_free;
    logic       take;
    t_res_set   res;

    // item moves from the input register into the result buffer
    assign take = in_valid && buf_free;

    upd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_last  (in_last)
    );

    upd_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .i_last  (in_last),
        .o_res   (res)
    );

    upd_res_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (res),
        .o_free     (buf_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_end      (m_axis_tlast),
        .o_run_last (m_axis_tuser[0])
    );

endmodule

`default_nettype wire
